>>> sv/point_to_polar_range_binner_core_macros.svh
// Assertion macros used by the checker file of the polar range binner.
`ifndef POINT_TO_POLAR_RANGE_BINNER_CORE_MACROS_SVH
`define POINT_TO_POLAR_RANGE_BINNER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define PPRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pprb: implication check failed");

// The consequent must hold in the cycle after reset is seen high.
`define PPRB_ASSERT_AFTER_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("pprb: post-reset check failed");

`endif

>>> sv/pprb_pkg.sv
package pprb_pkg;

  localparam int MAX_BINS_DEF     = 1024;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CW   = 17;  // coordinate width
  localparam int RW   = 17;  // range width
  localparam int AGW  = 16;  // angle width
  localparam int BIW  = 10;  // bin index port width
  localparam int STW  = 3;   // status width
  localparam int BCW  = 11;  // bin count register width
  localparam int CIW  = 3;   // configuration index width

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_TOO_NEAR   = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_NOT_NEARER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_ANGLE_MIN  = 3'd0,
    CFG_ANGLE_MAX  = 3'd1,
    CFG_ANGLE_STEP = 3'd2,
    CFG_RANGE_MIN  = 3'd3,
    CFG_RANGE_MAX  = 3'd4,
    CFG_BIN_COUNT  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_ITER,
    BK_ANGLE,
    BK_CHECK,
    BK_DIV,
    BK_CLAMP,
    BK_MEM_WAIT,
    BK_MEM_USE
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic                  pvalid;
    logic [BIW-1:0]        idx;
  } cmd_t;

  typedef struct packed {
    logic [AGW-1:0] win_lo;
    logic [AGW-1:0] win_hi;
    logic [AGW-1:0] angle_step;
    logic [RW-1:0]  near_lim;
    logic [RW-1:0]  far_lim;
    logic [BCW-1:0] bin_count;
  } cfg_t;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic [21:0] atan_turn(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2097152;
      5'd1:  v = 22'd1238021;
      5'd2:  v = 22'd654136;
      5'd3:  v = 22'd332050;
      5'd4:  v = 22'd166669;
      5'd5:  v = 22'd83416;
      5'd6:  v = 22'd41718;
      5'd7:  v = 22'd20860;
      5'd8:  v = 22'd10430;
      5'd9:  v = 22'd5215;
      5'd10: v = 22'd2608;
      5'd11: v = 22'd1304;
      5'd12: v = 22'd652;
      5'd13: v = 22'd326;
      5'd14: v = 22'd163;
      5'd15: v = 22'd81;
      5'd16: v = 22'd41;
      5'd17: v = 22'd20;
      5'd18: v = 22'd10;
      5'd19: v = 22'd5;
      5'd20: v = 22'd3;
      5'd21: v = 22'd1;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/pprb_front.sv
module pprb_front import pprb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 sweeping,
  input  logic [1:0]           operation,
  input  logic signed [CW-1:0] point_x,
  input  logic signed [CW-1:0] point_y,
  input  logic                 point_valid,
  input  logic [BIW-1:0]       read_index,
  output logic                 busy,
  output cmd_t                 cmd,
  output logic                 cmd_valid,
  input  logic                 cmd_pop
);

  // Two-entry command queue between the port and the execution side.
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       incoming;

  assign busy      = (count == 2'd2) || sweeping;
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    incoming.op     = op_t'(operation);
    incoming.x      = point_x;
    incoming.y      = point_y;
    incoming.pvalid = point_valid;
    incoming.idx    = read_index;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

>>> sv/pprb_back.sv
module pprb_back import pprb_pkg::*; #(
  parameter int MAX_BINS     = MAX_BINS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  cmd_t            cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  output logic            sweeping,
  output logic            done,
  output logic [RW-1:0]   range_out,
  output logic [BIW-1:0]  bin_index,
  output logic [STW-1:0]  status
);

  localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int ITERS = (CORDIC_STEPS > 18) ? CORDIC_STEPS : 18;
  localparam int ITW   = $clog2(ITERS);
  localparam logic [RW-1:0] MAXB = RW'(MAX_BINS);

  back_state_t state, state_next;

  logic [AW-1:0]        clr_cnt;
  logic                 clr_op;
  op_t                  op;
  logic signed [CW-1:0] xs, ys;
  logic [33:0]          sq_x, sq_y;
  logic [34:0]          sq_s, sroot, sbit;
  logic [ITW-1:0]       it;
  logic signed [27:0]   cx, cy;
  logic signed [25:0]   cz;
  logic                 origin;
  logic [RW-1:0]        rng;
  logic signed [AGW-1:0] ang;
  logic [RW-1:0]        dq;
  logic [AGW-1:0]       rem;
  logic [4:0]           dcnt;
  logic [AW-1:0]        raddr;
  logic [BIW-1:0]       bin_out;
  logic [RW:0]          rd_data;
  logic [RW:0]          mem [MAX_BINS];

  // Combinational helpers.
  logic [RW-1:0]        idx_ext;
  logic                 read_in_range;
  logic [RW:0]          dsum;
  logic [RW-1:0]        dflt;
  logic                 too_near, outside;
  logic signed [27:0]   xe, ye, dx, dy;
  logic signed [25:0]   atan_w, zr;
  logic [34:0]          trial;
  logic [RW-1:0]        dvd;
  logic [RW-1:0]        rem2;
  logic [RW-1:0]        cnt_c, bmax, bin_c;
  logic [RW-1:0]        cur;
  logic                 nearer;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [RW:0]          mem_wdata;

  assign sweeping = (state == BK_SWEEP) && !clr_op;

  always_comb begin
    idx_ext       = {{(RW-BIW){1'b0}}, cmd.idx};
    read_in_range = idx_ext < MAXB;
    dsum          = {1'b0, cfg.far_lim} + (RW+1)'(1000);
    dflt          = dsum[RW] ? {RW{1'b1}} : dsum[RW-1:0];
    too_near      = rng < cfg.near_lim;
    outside       = (ang < $signed(cfg.win_lo)) || (ang > $signed(cfg.win_hi))
                    || (cfg.angle_step == '0);
    xe            = {{3{xs[CW-1]}}, xs, 8'd0};
    ye            = {{3{ys[CW-1]}}, ys, 8'd0};
    dx            = cy >>> it;
    dy            = cx >>> it;
    atan_w        = {4'd0, atan_turn(5'(it))};
    zr            = (cz + 26'sd128) >>> 8;
    trial         = sroot + sbit;
    dvd           = {ang[AGW-1], ang} - {cfg.win_lo[AGW-1], cfg.win_lo};
    rem2          = {rem, dq[RW-1]};
    cnt_c         = {{(RW-BCW){1'b0}}, cfg.bin_count};
    if (cnt_c == '0) begin
      cnt_c = RW'(1);
    end
    if (cnt_c > MAXB) begin
      cnt_c = MAXB;
    end
    bmax          = cnt_c - RW'(1);
    bin_c         = (dq > bmax) ? bmax : dq;
    cur           = rd_data[RW] ? rd_data[RW-1:0] : dflt;
    nearer        = rng < cur;
  end

  // Bin store write port: the clearing sweep or an accepted insert.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = raddr;
    mem_wdata = {1'b1, rng};
    if (state == BK_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (state == BK_MEM_USE && op == OP_INSERT && nearer) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    case (state)
      BK_SWEEP: begin
        if (clr_cnt == AW'(MAX_BINS - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_CLEAR:  state_next = BK_SWEEP;
            OP_READ:   if (read_in_range) state_next = BK_MEM_WAIT;
            OP_INSERT: if (cmd.pvalid) state_next = BK_MUL;
            default:   state_next = BK_IDLE;
          endcase
        end
      end
      BK_MUL:   state_next = BK_SUM;
      BK_SUM:   state_next = BK_ITER;
      BK_ITER: begin
        if (it == ITW'(ITERS - 1)) state_next = BK_ANGLE;
      end
      BK_ANGLE: state_next = BK_CHECK;
      BK_CHECK: begin
        state_next = (too_near || outside) ? BK_IDLE : BK_DIV;
      end
      BK_DIV: begin
        if (dcnt == 5'(RW - 1)) state_next = BK_CLAMP;
      end
      BK_CLAMP:    state_next = BK_MEM_WAIT;
      BK_MEM_WAIT: state_next = BK_MEM_USE;
      BK_MEM_USE:  state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_SWEEP;
      clr_cnt <= '0;
      clr_op  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        BK_SWEEP: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAX_BINS - 1)) begin
            clr_cnt <= '0;
            clr_op  <= 1'b0;
            if (clr_op) begin
              done      <= 1'b1;
              range_out <= '0;
              bin_index <= '0;
              status    <= ST_OK;
            end
          end
        end
        BK_IDLE: begin
          if (cmd_valid) begin
            op <= cmd.op;
            case (cmd.op)
              OP_CLEAR: clr_op <= 1'b1;
              OP_READ: begin
                bin_out <= cmd.idx;
                raddr   <= idx_ext[AW-1:0];
                if (!read_in_range) begin
                  done      <= 1'b1;
                  range_out <= dflt;
                  bin_index <= cmd.idx;
                  status    <= ST_OK;
                end
              end
              OP_INSERT: begin
                xs <= cmd.x;
                ys <= cmd.y;
                if (!cmd.pvalid) begin
                  done      <= 1'b1;
                  range_out <= '0;
                  bin_index <= '0;
                  status    <= ST_INVALID;
                end
              end
              default: begin
                done      <= 1'b1;
                range_out <= '0;
                bin_index <= '0;
                status    <= ST_OK;
              end
            endcase
          end
        end
        BK_MUL: begin
          sq_x   <= xs * xs;
          sq_y   <= ys * ys;
          origin <= (xs == '0) && (ys == '0);
          if (xs[CW-1]) begin
            if (!ys[CW-1]) begin
              cx <= ye;
              cy <= -xe;
              cz <= 26'sd4194304;
            end else begin
              cx <= -ye;
              cy <= xe;
              cz <= -26'sd4194304;
            end
          end else begin
            cx <= xe;
            cy <= ye;
            cz <= '0;
          end
        end
        BK_SUM: begin
          sq_s  <= {1'b0, sq_x} + {1'b0, sq_y};
          sroot <= '0;
          sbit  <= 35'd1 << 34;
          it    <= '0;
        end
        BK_ITER: begin
          if (sbit != '0) begin
            if (sq_s >= trial) begin
              sq_s  <= sq_s - trial;
              sroot <= (sroot >> 1) + sbit;
            end else begin
              sroot <= sroot >> 1;
            end
            sbit <= sbit >> 2;
          end
          if (int'(it) < CORDIC_STEPS) begin
            if (!cy[27]) begin
              cx <= cx + dx;
              cy <= cy - dy;
              cz <= cz + atan_w;
            end else begin
              cx <= cx - dx;
              cy <= cy + dy;
              cz <= cz - atan_w;
            end
          end
          it <= it + ITW'(1);
        end
        BK_ANGLE: begin
          rng <= sroot[RW-1:0] + {{(RW-1){1'b0}}, (sq_s > sroot)};
          if (origin) begin
            ang <= '0;
          end else if (zr > 26'sd32767) begin
            ang <= 16'sh7FFF;
          end else if (zr < -26'sd32768) begin
            ang <= 16'sh8000;
          end else begin
            ang <= zr[AGW-1:0];
          end
        end
        BK_CHECK: begin
          if (too_near) begin
            done      <= 1'b1;
            range_out <= rng;
            bin_index <= '0;
            status    <= ST_TOO_NEAR;
          end else if (outside) begin
            done      <= 1'b1;
            range_out <= rng;
            bin_index <= '0;
            status    <= ST_OUTSIDE;
          end else begin
            dq   <= dvd;
            rem  <= '0;
            dcnt <= '0;
          end
        end
        BK_DIV: begin
          if (rem2 >= {1'b0, cfg.angle_step}) begin
            rem <= AGW'(rem2 - {1'b0, cfg.angle_step});
            dq  <= {dq[RW-2:0], 1'b1};
          end else begin
            rem <= rem2[AGW-1:0];
            dq  <= {dq[RW-2:0], 1'b0};
          end
          dcnt <= dcnt + 5'd1;
        end
        BK_CLAMP: begin
          bin_out <= bin_c[BIW-1:0];
          raddr   <= bin_c[AW-1:0];
        end
        BK_MEM_USE: begin
          done      <= 1'b1;
          bin_index <= bin_out;
          if (op == OP_READ) begin
            range_out <= cur;
            status    <= ST_OK;
          end else begin
            range_out <= rng;
            status    <= nearer ? ST_OK : ST_NOT_NEARER;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/point_to_polar_range_binner_core.sv
// An in-range read passes the bin store read and use; an invalid point or unused code is
// answered from idle. An insert runs the square root (18 digits) with the CORDIC angle
// search and, unless dropped, the bin division (17 quotient digits) and store update. A
// clear sweeps the store, one bin per cycle. The back side takes one word at a time and
// a two-word queue takes new words meanwhile. Results leave on done for one cycle and
// the receiver cannot stall them. Reset (rst, synchronous) clears every bin; busy is high.
module point_to_polar_range_binner_core import pprb_pkg::*; #(
  parameter int MAX_BINS     = MAX_BINS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation,
  input  logic signed [CW-1:0] point_x,
  input  logic signed [CW-1:0] point_y,
  input  logic                 point_valid,
  input  logic [BIW-1:0]       read_index,
  input  logic                 cfg_write,
  input  logic [CIW-1:0]       cfg_index,
  input  logic [RW-1:0]        cfg_data,
  output logic                 done,
  output logic [RW-1:0]        range_out,
  output logic [BIW-1:0]       bin_index,
  output logic [STW-1:0]       status
);

  // Configuration registers. Software writes them only while the block is idle (the block
  // does not enforce it), so the execution side reads them directly without a shadow copy.
  cfg_t cfg;

  // The front side owns the port handshake and a short word queue; the back side runs the
  // square root, the CORDIC angle search, the bin division and the bin store. The queue
  // lets the port take a word while the back side is still grinding on an insert.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic sweeping;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_lo     <= 16'h8000;
      cfg.win_hi     <= 16'h7FFF;
      cfg.angle_step <= 16'd64;
      cfg.near_lim   <= '0;
      cfg.far_lim    <= RW'(30000);
      cfg.bin_count  <= BCW'(1024);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ANGLE_MIN:  cfg.win_lo     <= cfg_data[AGW-1:0];
        CFG_ANGLE_MAX:  cfg.win_hi     <= cfg_data[AGW-1:0];
        CFG_ANGLE_STEP: cfg.angle_step <= cfg_data[AGW-1:0];
        CFG_RANGE_MIN:  cfg.near_lim   <= cfg_data;
        CFG_RANGE_MAX:  cfg.far_lim    <= cfg_data;
        CFG_BIN_COUNT:  cfg.bin_count  <= cfg_data[BCW-1:0];
        default: ;
      endcase
    end
  end

  pprb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sweeping    (sweeping),
    .operation   (operation),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .read_index  (read_index),
    .busy        (busy),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop)
  );

  // A bin that fails the nearer-than-stored test is left as it is and reported with its
  // index; every other drop reports bin zero.
  pprb_back #(
    .MAX_BINS     (MAX_BINS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .sweeping  (sweeping),
    .done      (done),
    .range_out (range_out),
    .bin_index (bin_index),
    .status    (status)
  );

endmodule

>>> sv/pprb_checker.sv
`include "point_to_polar_range_binner_core_macros.svh"

module pprb_checker import pprb_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 busy,
  input logic                 done,
  input logic [RW-1:0]        range_out,
  input logic [BIW-1:0]       bin_index,
  input logic [STW-1:0]       status
);

  `PPRB_ASSERT_IMPL(a_status_known, clk, rst, done, status <= ST_NOT_NEARER)
  `PPRB_ASSERT_IMPL(a_invalid_zero, clk, rst, done && status == ST_INVALID, range_out == '0 && bin_index == '0)
  `PPRB_ASSERT_IMPL(a_drop_bin_zero, clk, rst, done && (status == ST_TOO_NEAR || status == ST_OUTSIDE), bin_index == '0)
  `PPRB_ASSERT_AFTER_RST(a_reset_sweep, clk, rst, busy && !done)

endmodule

bind point_to_polar_range_binner_core pprb_checker u_pprb_checker (.*);
